/* src/ledpg_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the LED / buzzer pattern generator.
// Mode codes, field widths, pattern thresholds and reset values; no dependencies.
package ledpg_pkg;

  // Default geometry
  localparam int NUM_CHANNELS_DEF = 5;
  localparam int COUNT_WIDTH_DEF  = 16;

  // Field widths fixed by the stream format
  localparam int ACTION_W  = 1;
  localparam int CHANNEL_W = 3;
  localparam int MODE_W    = 4;
  localparam int PIN_W     = 5;   // mask, request and pin_levels widths
  localparam int S_DATA_W  = 16;  // channel, new_mode, request mask, zero pad
  localparam int M_DATA_W  = 8;   // pin_levels, zero pad

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_TICK     = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_SET_MODE = 1'b1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_OFF    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_ON     = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SLOW   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_FAST   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ONCE   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_BEEP   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_FLASH  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 4'd7;
  localparam logic [MODE_W-1:0] MODE_COMBI  = 4'd8;

  // Pattern thresholds, in ticks
  localparam int SLOW_ON_MAX   = 50;
  localparam int SLOW_WRAP     = 100;
  localparam int FAST_ON_MAX   = 10;
  localparam int FAST_WRAP     = 20;
  localparam int ONCE_ON_MAX   = 2;
  localparam int BEEP_ON_MAX   = 25;
  localparam int FLASH_ON_LT   = 2;
  localparam int FLASH_WRAP    = 200;
  localparam int COMBI_A_END   = 10;
  localparam int COMBI_B_START = 50;
  localparam int COMBI_B_END   = 60;
  localparam int COMBI_C_START = 100;
  localparam int COMBI_C_END   = 150;
  localparam int COMBI_WRAP    = 200;

  // Channel 0 is the life LED
  localparam int LIFE_CHANNEL = 0;

endpackage

/* src/led_pattern_generator_core.sv */
`timescale 1ns / 1ps
// LED / buzzer pattern generator: per-channel mode, tick counter and pin level.
// Depends on ledpg_pkg.
//
// Each accepted item (tick or set_mode) is applied to the channel state in the
// cycle it is taken, and its pin_levels result is pushed into a two-entry output
// queue, so one item per clock is sustained; the input stalls only when both
// queue entries hold results that the sink has not taken. Per-channel work is a
// handful of constant compares and one counter increment, all in parallel.
// After reset the life LED runs slow blink (pin high), the others are off, and
// every counter reads one. Polarity writes on the cfg channel are always taken
// and apply from the next tick that drives a pin.
module led_pattern_generator_core #(
  parameter int NUM_CHANNELS = ledpg_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = ledpg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [2:0] channel, [6:3] new_mode, [11:7] toggle_request_mask, [15:12] zero
  input  logic [ledpg_pkg::S_DATA_W-1:0]  s_tdata,
  // [0] action
  input  logic [ledpg_pkg::ACTION_W-1:0]  s_tuser,
  // Results
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [4:0] pin_levels, [7:5] zero
  output logic [ledpg_pkg::M_DATA_W-1:0]  m_tdata,
  // Polarity register write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ledpg_pkg::PIN_W-1:0]     cfg_data
);

  localparam int PW = ledpg_pkg::PIN_W;
  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  // Input field unpacking
  logic [ledpg_pkg::CHANNEL_W-1:0] in_channel;
  logic [ledpg_pkg::MODE_W-1:0]    in_new_mode;
  logic [PW-1:0]                   in_req;
  logic                            in_fire;
  logic                            in_tick;

  assign in_channel  = s_tdata[ledpg_pkg::CHANNEL_W-1:0];
  assign in_new_mode = s_tdata[ledpg_pkg::CHANNEL_W +: ledpg_pkg::MODE_W];
  assign in_req      = s_tdata[ledpg_pkg::CHANNEL_W + ledpg_pkg::MODE_W +: PW];
  assign in_fire     = s_tvalid && s_tready;
  assign in_tick     = (s_tuser == ledpg_pkg::ACT_TICK);

  // Polarity register
  logic [PW-1:0] neg_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      neg_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      neg_mask <= cfg_data;
    end
  end

  // Channel state
  logic [ledpg_pkg::MODE_W-1:0] channel_mode [NUM_CHANNELS];
  logic [CW-1:0]                tick_count   [NUM_CHANNELS];
  logic                         pin_level    [NUM_CHANNELS];
  logic                         pin_step     [NUM_CHANNELS];

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    logic                         neg;
    logic                         req;
    logic                         set_hit;
    logic [ledpg_pkg::MODE_W-1:0] mode_step;
    logic [CW-1:0]                cnt_wrap;
    logic [CW-1:0]                cnt_step;
    logic [CW-1:0]                n;

    // Channels past the field width see no polarity or request bit
    if (c < PW) begin : g_io
      assign neg = neg_mask[c];
      assign req = in_req[c];
    end else begin : g_no_io
      assign neg = 1'b0;
      assign req = 1'b0;
    end

    assign n = tick_count[c];
    assign set_hit = (32'(in_channel) == c) && (channel_mode[c] != in_new_mode);

    // Evaluate one tick for this channel
    always_comb begin
      mode_step   = channel_mode[c];
      cnt_wrap    = n;
      pin_step[c] = pin_level[c];
      case (channel_mode[c])
        ledpg_pkg::MODE_OFF: begin
          pin_step[c] = neg;
        end
        ledpg_pkg::MODE_ON: begin
          pin_step[c] = ~neg;
        end
        ledpg_pkg::MODE_SLOW: begin
          pin_step[c] = (n <= CW'(ledpg_pkg::SLOW_ON_MAX)) ^ neg;
          if (n >= CW'(ledpg_pkg::SLOW_WRAP)) cnt_wrap = '0;
        end
        ledpg_pkg::MODE_FAST: begin
          pin_step[c] = (n <= CW'(ledpg_pkg::FAST_ON_MAX)) ^ neg;
          if (n >= CW'(ledpg_pkg::FAST_WRAP)) cnt_wrap = '0;
        end
        ledpg_pkg::MODE_ONCE, ledpg_pkg::MODE_BEEP: begin
          if (n <= ((channel_mode[c] == ledpg_pkg::MODE_ONCE) ?
                    CW'(ledpg_pkg::ONCE_ON_MAX) : CW'(ledpg_pkg::BEEP_ON_MAX))) begin
            pin_step[c] = ~neg;
          end else begin
            pin_step[c] = neg;
            mode_step   = ledpg_pkg::MODE_OFF;
            cnt_wrap    = '0;
          end
        end
        ledpg_pkg::MODE_FLASH: begin
          pin_step[c] = (n < CW'(ledpg_pkg::FLASH_ON_LT)) ^ neg;
          if (n >= CW'(ledpg_pkg::FLASH_WRAP)) cnt_wrap = '0;
        end
        ledpg_pkg::MODE_TOGGLE: begin
          pin_step[c] = pin_level[c] ^ req;
        end
        ledpg_pkg::MODE_COMBI: begin
          if (n < CW'(ledpg_pkg::COMBI_WRAP)) begin
            pin_step[c] = ((n < CW'(ledpg_pkg::COMBI_A_END)) ||
                           (n >= CW'(ledpg_pkg::COMBI_B_START) &&
                            n <  CW'(ledpg_pkg::COMBI_B_END)) ||
                           (n >= CW'(ledpg_pkg::COMBI_C_START) &&
                            n <  CW'(ledpg_pkg::COMBI_C_END))) ^ neg;
          end else begin
            cnt_wrap = '0;
          end
        end
        default: begin
          // Undefined codes hold the pin; the counter still advances
        end
      endcase
      cnt_step = (cnt_wrap < CNT_MAX) ? cnt_wrap + CW'(1) : cnt_wrap;
    end

    // Update state on an accepted transfer
    always_ff @(posedge clk) begin
      if (rst) begin
        channel_mode[c] <= (c == ledpg_pkg::LIFE_CHANNEL) ?
                           ledpg_pkg::MODE_SLOW : ledpg_pkg::MODE_OFF;
        tick_count[c]   <= CW'(1);
        pin_level[c]    <= (c == ledpg_pkg::LIFE_CHANNEL);
      end else if (in_fire) begin
        if (in_tick) begin
          channel_mode[c] <= mode_step;
          tick_count[c]   <= cnt_step;
          pin_level[c]    <= pin_step[c];
        end else if (set_hit) begin
          channel_mode[c] <= in_new_mode;
          tick_count[c]   <= '0;
        end
      end
    end
  end

  // Gather the reported pin word
  logic [PW-1:0] pins_cur;
  logic [PW-1:0] pins_tick;
  logic [PW-1:0] result;

  for (genvar i = 0; i < PW; i++) begin : g_pins
    if (i < NUM_CHANNELS) begin : g_used
      assign pins_cur[i]  = pin_level[i];
      assign pins_tick[i] = pin_step[i];
    end else begin : g_unused
      assign pins_cur[i]  = 1'b0;
      assign pins_tick[i] = 1'b0;
    end
  end

  assign result = in_tick ? pins_tick : pins_cur;

  // Two-entry output queue: head drives m_tdata, tail catches a stalled result
  logic [PW-1:0] out_head;
  logic [PW-1:0] out_tail;
  logic [1:0]    out_count;
  logic          out_pop;

  assign out_pop  = m_tvalid && m_tready;
  assign m_tvalid = (out_count != 2'd0);
  assign s_tready = (out_count != 2'd2);
  assign m_tdata  = {{(ledpg_pkg::M_DATA_W - PW){1'b0}}, out_head};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
    end else begin
      out_count <= out_count + {1'b0, in_fire} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop) begin
      if (out_count == 2'd2) begin
        out_head <= out_tail;
        if (in_fire) out_tail <= result;
      end else if (in_fire) begin
        out_head <= result;
      end
    end else if (in_fire) begin
      if (out_count == 2'd0) begin
        out_head <= result;
      end else begin
        out_tail <= result;
      end
    end
  end

endmodule

/* src/ledpg_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for led_pattern_generator_core, bound to the top level.
// Depends on ledpg_pkg for field widths.
module ledpg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ledpg_pkg::M_DATA_W-1:0] m_tdata
);

  // Queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // With no result waiting, the input must be open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output queue");

  // Every transfer into an empty block yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> m_tvalid)
    else $error("accepted item produced no result");

  // A stalled result holds its data
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind led_pattern_generator_core ledpg_checker u_ledpg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
